[rtl/core/md5_pkg.sv]
// MD5 package: initial chaining words, round constants, rotate amounts,
// message word order and the working-register struct.
// No dependencies; used by md5_round and md5_hash_engine.
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam int BlockWords = 16;
    localparam logic [5:0] LastRound = 6'd63;
    localparam logic [5:0] PadLimit = 6'd56;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [1:0] LastWordIndex = 2'd3;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_work_t;

    // Additive constant of each round
    function automatic logic [31:0] md5_round_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left-rotate amount: depends on the round group and the round mod 4
    function automatic logic [4:0] md5_rot_amount(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'b0000: s = 5'd7;   4'b0001: s = 5'd12;
            4'b0010: s = 5'd17;  4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;   4'b0101: s = 5'd9;
            4'b0110: s = 5'd14;  4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;   4'b1001: s = 5'd11;
            4'b1010: s = 5'd16;  4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;   4'b1101: s = 5'd10;
            4'b1110: s = 5'd15;  4'b1111: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used in each round, all arithmetic modulo 16
    function automatic logic [3:0] md5_msg_index(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] g;
        lo = r[3:0];
        unique case (r[5:4])
            2'd0: g = lo;
            2'd1: g = lo + {lo[1:0], 2'b00} + 4'd1;
            2'd2: g = lo + {lo[2:0], 1'b0} + 4'd5;
            2'd3: g = {lo[0], 3'b000} - lo;
            default: g = lo;
        endcase
        return g;
    endfunction

endpackage

[rtl/core/md5_hash_engine.sv]
// MD5 hash engine: byte stream in, four digest words out per message.
// Data bytes are taken while idle; every 64th byte starts the 64 rounds on the
// shared round unit, followed by the chaining add. End of message pads the
// block and compresses it, plus a second length-only block when padding
// spills, then four output transfers. Reset (rst_n low, async) restores the initial
// chaining value and clears the byte count; the block buffer is not reset.
module md5_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind: 0 data byte, 1 end of message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] hash_word
    output logic [1:0]  m_tuser,   // [1:0] word_index
    output logic        m_tlast    // last_word
);
    import md5_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD2,
        ST_DIGEST
    } state_t;

    state_t      state_reg;
    logic [5:0]  round_reg;
    logic        final_reg;
    logic        second_reg;
    logic        m_tvalid_reg;
    logic [1:0]  out_idx_reg;

    logic [31:0] cv_reg [4];
    md5_work_t   work_reg;
    md5_work_t   work_next;
    logic [63:0] count_reg;
    logic [31:0] buf_reg [BlockWords];

    logic [5:0]  pos;
    logic [3:0]  pos_word;
    logic [1:0]  pos_lane;
    logic [63:0] bit_len;
    logic        data_xfer;
    logic        end_xfer;
    logic        out_xfer;
    logic        spill;
    logic        load_work;

    assign pos       = count_reg[5:0];
    assign pos_word  = pos[5:2];
    assign pos_lane  = pos[1:0];
    assign bit_len   = {count_reg[60:0], 3'b000};
    assign spill     = (pos >= PadLimit);

    assign s_tready  = (state_reg == ST_IDLE);
    assign data_xfer = s_tvalid && s_tready && !s_tuser;
    assign end_xfer  = s_tvalid && s_tready && s_tuser;
    assign out_xfer  = m_tvalid_reg && m_tready;
    assign load_work = (data_xfer && (pos == LastRound)) || end_xfer
                       || (state_reg == ST_PAD2);

    // Shared round unit
    md5_round u_round (
        .round_idx (round_reg),
        .work_in   (work_reg),
        .msg_word  (buf_reg[md5_msg_index(round_reg)]),
        .work_out  (work_next)
    );

    // Sequencer: state, round counter, message flags, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            final_reg    <= 1'b0;
            second_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            out_idx_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (end_xfer)
                    begin
                        final_reg  <= 1'b1;
                        second_reg <= spill;
                        round_reg  <= '0;
                        state_reg  <= ST_ROUND;
                    end
                    else if (data_xfer && (pos == LastRound))
                    begin
                        round_reg <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    // Counter wraps back to zero after the last round
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == LastRound)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    if (final_reg && second_reg)
                    begin
                        state_reg <= ST_PAD2;
                    end
                    else if (final_reg)
                    begin
                        m_tvalid_reg <= 1'b1;
                        out_idx_reg  <= '0;
                        state_reg    <= ST_DIGEST;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PAD2:
                begin
                    second_reg <= 1'b0;
                    round_reg  <= '0;
                    state_reg  <= ST_ROUND;
                end
                ST_DIGEST:
                begin
                    if (out_xfer)
                    begin
                        if (out_idx_reg == LastWordIndex)
                        begin
                            m_tvalid_reg <= 1'b0;
                            final_reg    <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end
                        else
                        begin
                            out_idx_reg <= out_idx_reg + 2'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Chaining value, working registers and byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= IV_A;
            cv_reg[1] <= IV_B;
            cv_reg[2] <= IV_C;
            cv_reg[3] <= IV_D;
            work_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (data_xfer)
            begin
                count_reg <= count_reg + 64'd1;
            end
            if (load_work)
            begin
                work_reg <= '{a: cv_reg[0], b: cv_reg[1], c: cv_reg[2], d: cv_reg[3]};
            end
            else if (state_reg == ST_ROUND)
            begin
                work_reg <= work_next;
            end
            if (state_reg == ST_ADD)
            begin
                cv_reg[0] <= cv_reg[0] + work_reg.a;
                cv_reg[1] <= cv_reg[1] + work_reg.b;
                cv_reg[2] <= cv_reg[2] + work_reg.c;
                cv_reg[3] <= cv_reg[3] + work_reg.d;
            end
            // Return to the initial state after the last digest word
            if ((state_reg == ST_DIGEST) && out_xfer && (out_idx_reg == LastWordIndex))
            begin
                cv_reg[0] <= IV_A;
                cv_reg[1] <= IV_B;
                cv_reg[2] <= IV_C;
                cv_reg[3] <= IV_D;
                work_reg  <= '0;
                count_reg <= '0;
            end
        end
    end

    // Block buffer: byte packing and padding
    always_ff @(posedge clk)
    begin
        if (data_xfer)
        begin
            unique case (pos_lane)
                2'd0: buf_reg[pos_word]        <= {24'h0, s_tdata};
                2'd1: buf_reg[pos_word][15:8]  <= s_tdata;
                2'd2: buf_reg[pos_word][23:16] <= s_tdata;
                2'd3: buf_reg[pos_word][31:24] <= s_tdata;
                default: buf_reg[pos_word]     <= {24'h0, s_tdata};
            endcase
        end
        else if (end_xfer)
        begin
            // Append the pad byte, clear everything after it up to the length words (to the block end on a spill)
            for (int i = 0; i < BlockWords; i++)
            begin
                if (4'(i) == pos_word)
                begin
                    unique case (pos_lane)
                        2'd0: buf_reg[i] <= {24'h0, PadByte};
                        2'd1: buf_reg[i] <= {16'h0, PadByte, buf_reg[i][7:0]};
                        2'd2: buf_reg[i] <= {8'h0, PadByte, buf_reg[i][15:0]};
                        2'd3: buf_reg[i] <= {PadByte, buf_reg[i][23:0]};
                        default: buf_reg[i] <= {24'h0, PadByte};
                    endcase
                end
                else if ((4'(i) > pos_word) && (spill || (i < BlockWords - 2)))
                begin
                    buf_reg[i] <= '0;
                end
            end
            if (!spill)
            begin
                buf_reg[BlockWords-2] <= bit_len[31:0];
                buf_reg[BlockWords-1] <= bit_len[63:32];
            end
        end
        else if (state_reg == ST_PAD2)
        begin
            // Length-only block after a spill
            for (int i = 0; i < BlockWords - 2; i++)
            begin
                buf_reg[i] <= '0;
            end
            buf_reg[BlockWords-2] <= bit_len[31:0];
            buf_reg[BlockWords-1] <= bit_len[63:32];
        end
    end

    // Digest output
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = cv_reg[out_idx_reg];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == LastWordIndex);

    // Input and output sides never open together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while digest pending");

    // After the last digest transfer the engine is idle with a cleared count
    a_clear_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && (count_reg == 64'd0)))
        else $error("engine not cleared after digest");

    // An end-of-message transfer starts the rounds on the next cycle
    a_end_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> (state_reg == ST_ROUND && round_reg == 6'd0))
        else $error("end of message did not start compression");

endmodule

[rtl/core/md5_round.sv]
// MD5 round unit: one of the 64 rounds on the working registers per use.
// Depends on md5_pkg (constants, rotate table, md5_work_t).
module md5_round (
    input  logic [5:0]        round_idx,
    input  md5_pkg::md5_work_t work_in,
    input  logic [31:0]       msg_word,
    output md5_pkg::md5_work_t work_out
);
    import md5_pkg::*;

    logic [31:0] f;
    logic [31:0] t;
    logic [4:0]  rot;
    logic [63:0] rot_wide;

    // Select the boolean function of the round group
    always_comb
    begin
        unique case (round_idx[5:4])
            2'd0: f = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
            2'd1: f = (work_in.d & work_in.b) | (~work_in.d & work_in.c);
            2'd2: f = work_in.b ^ work_in.c ^ work_in.d;
            2'd3: f = work_in.c ^ (work_in.b | ~work_in.d);
            default: f = '0;
        endcase
    end

    // Sum, rotate and rotate the register roles
    assign t        = work_in.a + f + md5_round_const(round_idx) + msg_word;
    assign rot      = md5_rot_amount(round_idx);
    assign rot_wide = {t, t} << rot;

    assign work_out.a = work_in.d;
    assign work_out.b = work_in.b + rot_wide[63:32];
    assign work_out.c = work_in.b;
    assign work_out.d = work_in.c;

endmodule
